// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps

package bcc_pkg;

  // field and register widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SPAN_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'd1;

  // register reset values
  localparam logic [SPAN_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [SPAN_W-1:0] WINDOW_RST   = 16'd400;

  // action codes
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } bcc_event_e;

  typedef enum logic [2:0] {
    PH_BOOT_WAIT     = 3'd0,
    PH_IDLE          = 3'd1,
    PH_DEBOUNCE      = 3'd2,
    PH_HELD          = 3'd3,
    PH_REL_DEBOUNCE  = 3'd4,
    PH_WINDOW        = 3'd5,
    PH_SECOND_DEB    = 3'd6,
    PH_FINAL_RELEASE = 3'd7
  } bcc_phase_e;

  // one input beat
  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] now_ms;
    logic              pressed;
  } bcc_item_t;

  // wrapping elapsed-time check
  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] since,
                                   input logic [SPAN_W-1:0] span);
    logic [TIME_W-1:0] diff;
    diff = now - since;
    return diff >= {{(TIME_W-SPAN_W){1'b0}}, span};
  endfunction

endpackage

// ===== rtl/bcc_in_reg.sv =====
`timescale 1ns / 1ps

module bcc_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bcc_pkg::bcc_item_t  item_i,
  input  logic                step_i,
  output logic                valid_o,
  output bcc_pkg::bcc_item_t  item_o
);
  import bcc_pkg::*;

  logic      valid_q;
  bcc_item_t item_q;
  logic      load;

  // register takes a beat when empty or when its beat moves on
  assign load       = !valid_q || step_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

`ifndef SYNTHESIS
  a_step_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> valid_q)
    else $error("step without a held beat");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> valid_q && !step_i)
    else $error("input stalled while register free");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !step_i |=> valid_q && $stable(item_q))
    else $error("held beat lost");
`endif

endmodule

// ===== rtl/bcc_core.sv =====
`timescale 1ns / 1ps

module bcc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  bcc_pkg::bcc_item_t            item_i,
  input  logic [bcc_pkg::SPAN_W-1:0]    debounce_i,
  input  logic [bcc_pkg::SPAN_W-1:0]    window_i,
  output bcc_pkg::bcc_event_e           event_o
);
  import bcc_pkg::*;

  bcc_phase_e        phase_q, phase_d;
  logic [TIME_W-1:0] phase_t_q, phase_t_d;
  logic [TIME_W-1:0] press_t_q, press_t_d;
  logic [TIME_W-1:0] win_t_q, win_t_d;
  bcc_event_e        ev;

  logic deb_done, hold_long, win_done;

  // the three timing compares
  assign deb_done  = elapsed(item_i.now_ms, phase_t_q, debounce_i);
  assign hold_long = elapsed(item_i.now_ms, press_t_q, window_i);
  assign win_done  = elapsed(item_i.now_ms, win_t_q, window_i);

  // next phase and event
  always_comb begin
    phase_d   = phase_q;
    phase_t_d = phase_t_q;
    press_t_d = press_t_q;
    win_t_d   = win_t_q;
    ev        = EV_NONE;
    if (item_i.action == ACT_START) begin
      if (item_i.pressed) begin
        phase_d   = PH_BOOT_WAIT;
        phase_t_d = item_i.now_ms;
      end else begin
        phase_d = PH_IDLE;
      end
    end else begin
      unique case (phase_q)
        PH_BOOT_WAIT: begin
          if (item_i.pressed) begin
            phase_t_d = item_i.now_ms;
          end else if (deb_done) begin
            phase_d = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (item_i.pressed) begin
            phase_t_d = item_i.now_ms;
            phase_d   = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (!item_i.pressed) begin
            phase_d = PH_IDLE;
          end else if (deb_done) begin
            press_t_d = item_i.now_ms;
            phase_d   = PH_HELD;
          end
        end
        PH_HELD: begin
          if (!item_i.pressed) begin
            phase_t_d = item_i.now_ms;
            phase_d   = PH_REL_DEBOUNCE;
          end
        end
        PH_REL_DEBOUNCE: begin
          if (item_i.pressed) begin
            phase_d = PH_HELD;
          end else if (deb_done) begin
            if (hold_long) begin
              phase_d = PH_IDLE;
              ev      = EV_SINGLE;
            end else begin
              win_t_d = item_i.now_ms;
              phase_d = PH_WINDOW;
            end
          end
        end
        PH_WINDOW: begin
          if (win_done) begin
            phase_d = PH_IDLE;
            ev      = EV_SINGLE;
          end else if (item_i.pressed) begin
            phase_t_d = item_i.now_ms;
            phase_d   = PH_SECOND_DEB;
          end
        end
        PH_SECOND_DEB: begin
          if (!item_i.pressed) begin
            phase_d = PH_WINDOW;
          end else if (deb_done) begin
            phase_d = PH_FINAL_RELEASE;
            ev      = EV_DOUBLE;
          end
        end
        PH_FINAL_RELEASE: begin
          if (!item_i.pressed) begin
            phase_t_d = item_i.now_ms;
            phase_d   = PH_IDLE;
          end
        end
      endcase
    end
  end

  // state advances once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      phase_t_q <= '0;
      press_t_q <= '0;
      win_t_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      phase_t_q <= phase_t_d;
      press_t_q <= press_t_d;
      win_t_q   <= win_t_d;
    end
  end

  assign event_o = ev;

`ifndef SYNTHESIS
  a_boot_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == ACT_START && item_i.pressed |=> phase_q == PH_BOOT_WAIT)
    else $error("start with button held did not enter boot wait");
  a_double_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ev == EV_DOUBLE |=> phase_q == PH_FINAL_RELEASE)
    else $error("double press without final release phase");
  a_single_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev == EV_SINGLE |-> phase_q == PH_REL_DEBOUNCE || phase_q == PH_WINDOW)
    else $error("single press from wrong phase");
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(phase_t_q))
    else $error("state moved without a beat");
`endif

endmodule

// ===== rtl/bcc_out_reg.sv =====
`timescale 1ns / 1ps

module bcc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  bcc_pkg::bcc_event_e  event_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           event_res_o,
  output logic                 free_o
);
  import bcc_pkg::*;

  logic       valid_q;
  bcc_event_e event_q;

  // free when empty or its beat leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      event_q <= event_i;
    end
  end

  assign out_valid_o = valid_q;
  assign event_res_o = event_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten while stalled");
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> event_q == EV_NONE || event_q == EV_SINGLE || event_q == EV_DOUBLE)
    else $error("bad event code held");
  a_keep_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |=> valid_q && $stable(event_q))
    else $error("stalled result dropped");
`endif

endmodule

// ===== rtl/button_click_classifier_top.sv =====
`timescale 1ns / 1ps

// Button click classifier: turns timestamped samples of a push button into
// single and double press events.
// Input channel: in_valid_i / in_stall_o carry action_i (start or sample),
// now_ms_i (wrapping ms time) and pressed_i. A beat moves on a rising edge
// with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry event_res_o (none, single,
// double); every input beat gives exactly one output beat, in order.
// The accepted beat passes through the input register, then through the phase
// logic into the result register. Throughput is one beat per cycle while the
// receiver does not stall; the phase update with its three 32-bit
// subtract-and-compare paths lies between the two registers.
// When the receiver stalls, the result register holds its beat and the input
// register fills; the input side then stalls too, with nothing dropped.
// Reset (rst_ni low, asynchronous) empties both registers, puts the phase
// machine in idle with zero timestamps, loads debounce 50 ms, window 400 ms.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the next edge;
// the user makes them only while the block is idle; it does not enforce this.

module button_click_classifier_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcc_pkg::SPAN_W-1:0]     cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [bcc_pkg::TIME_W-1:0]     now_ms_i,
  input  logic                           pressed_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     event_res_o
);
  import bcc_pkg::*;

  logic [SPAN_W-1:0] debounce_q;
  logic [SPAN_W-1:0] window_q;
  bcc_item_t         in_item;
  bcc_item_t         held_item;
  logic              held_valid;
  logic              out_free;
  logic              step;
  bcc_event_e        ev;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      window_q   <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        REG_WINDOW:   window_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.action  = action_i;
  assign in_item.now_ms  = now_ms_i;
  assign in_item.pressed = pressed_i;

  // a held beat moves into the result register when it has room
  assign step = held_valid && out_free;

  bcc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .step_i     (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  bcc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (held_item),
    .debounce_i (debounce_q),
    .window_i   (window_q),
    .event_o    (ev)
  );

  bcc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .event_i     (ev),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .free_o      (out_free)
  );

`ifndef SYNTHESIS
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(debounce_q) && $stable(window_q))
    else $error("configuration changed without a write");
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("beat lost between stages");
  a_stall_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result side free");
`endif

endmodule
